// ===== hdl/btree_node_page_engine_top_assert.svh =====
// Assertion macros for the node page engine.
`ifndef BTREE_NODE_PAGE_ENGINE_TOP_ASSERT_SVH
`define BTREE_NODE_PAGE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication
`define BNPE_ASSERT_SAME(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("bnpe same-cycle check failed");

// Next-cycle implication
`define BNPE_ASSERT_NEXT(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("bnpe next-cycle check failed");

`endif

// ===== hdl/bnpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bnpe_pkg;

   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        a;
      logic [15:0]        b;
   } payload_type;

   typedef struct packed {
      logic        valid;
      payload_type pay;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_COMPACT,
      CELL_WRITE
   } cell_cmd_type;

   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_LOOKUP  = 3'd1;
   localparam logic [2:0] OP_CHILD   = 3'd2;
   localparam logic [2:0] OP_SPLIT   = 3'd3;
   localparam logic [2:0] OP_COMPACT = 3'd4;
   localparam logic [2:0] OP_MIDDLE  = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_WRONG_TYPE = 3'd3;
   localparam logic [2:0] ST_NO_VALID   = 3'd4;

   localparam logic CSR_NODE_IS_LEAF    = 1'b0;
   localparam logic CSR_RIGHTMOST_CHILD = 1'b1;

   localparam int SPLIT_MAX = 64;

endpackage

`default_nettype wire

// ===== hdl/bnpe_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bnpe_cell #(
   parameter int IDX = 0,
   parameter int UW  = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bnpe_pkg::cell_cmd_type cmd,
   input  logic [UW-1:0]          used_slots,
   input  bnpe_pkg::entry_type    nbr_in,
   input  bnpe_pkg::payload_type  wr_pay,
   input  logic                   hole_in,
   output logic                   hole_out,
   output bnpe_pkg::entry_type    entry_out
);
   import bnpe_pkg::*;

   logic        valid_ff, valid_in;
   payload_type pay_ff, pay_in;
   logic        below_used;

   assign below_used = UW'(IDX) < used_slots;
   // a hole anywhere at or below this slot pulls this slot one place down
   assign hole_out   = hole_in | (!valid_ff && below_used);
   assign entry_out  = '{valid: valid_ff, pay: pay_ff};

   always_comb begin
      valid_in = valid_ff;
      pay_in   = pay_ff;
      case (cmd)
         CELL_SHIFT: begin
            valid_in = nbr_in.valid;
            pay_in   = nbr_in.pay;
         end
         CELL_COMPACT: begin
            if (hole_out) begin
               valid_in = nbr_in.valid;
               pay_in   = nbr_in.pay;
            end
         end
         CELL_WRITE: begin
            if (UW'(IDX) == used_slots) begin
               valid_in = 1'b1;
               pay_in   = wr_pay;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

endmodule

`default_nettype wire

// ===== hdl/btree_node_page_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: insert and wrong-type errors go straight to the result beat; lookup, child search
// and middle key first scan the row; split scans and then compacts; compact only compacts,
// closing the invalid slots below the slot count that it finds when compaction starts.
// Throughput: one item at a time; the scan rotates the row of ENTRIES cells once, one slot
// a cycle, and compaction closes one hole a cycle. Output stall holds the rotation.
// Reset (synchronous, active high) clears all valid marks and the slot count, sets the
// page to leaf and the rightmost child to 0. Keys and values are undefined until written.

module btree_node_page_engine_top #(
   parameter int ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_key,
   input  logic [15:0]        req_value_a,
   input  logic [15:0]        req_value_b,
   input  logic               req_invalidate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_result_key,
   output logic [15:0]        rsp_result_a,
   output logic [15:0]        rsp_result_b,
   output logic [5:0]         rsp_slot_index,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data
);
   import bnpe_pkg::*;

   localparam int UW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_FINAL
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic               inv_ff, inv_in;
   logic [UW-1:0]      used_ff, used_in;
   logic [UW-1:0]      cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   logic               err_ff, err_in;
   logic               full_ff, full_in;
   logic [6:0]         moved_ff, moved_in;
   logic signed [31:0] res_key_ff, res_key_in;
   logic [15:0]        res_a_ff, res_a_in;
   logic [15:0]        res_b_ff, res_b_in;
   logic [5:0]         res_slot_ff, res_slot_in;
   logic               leaf_ff;
   logic [15:0]        rmc_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_found_ff, rsp_found_in;
   logic signed [31:0] rsp_key_ff, rsp_key_in;
   logic [15:0]        rsp_a_ff, rsp_a_in;
   logic [15:0]        rsp_b_ff, rsp_b_in;
   logic [5:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;
   logic               out_free;
   logic               accept;

   cell_cmd_type       cell_cmd;
   entry_type          chain [ENTRIES];
   entry_type          tail;
   entry_type          head;
   payload_type        wr_pay;
   logic [ENTRIES:0]   hole;
   logic               hole_any;

   // ---------------------------------------------------------------
   // Row of cells: cell 0 is the head seen by the scan; the last cell
   // takes the fed-back head while rotating, an empty slot while compacting.
   // ---------------------------------------------------------------
   assign hole[0]  = 1'b0;
   assign hole_any = hole[ENTRIES];
   assign head     = chain[0];
   assign wr_pay   = '{key: req_key, a: req_value_a, b: req_value_b};

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
      entry_type nbr;
      if (gi == ENTRIES - 1) begin : g_tail
         assign nbr = tail;
      end else begin : g_mid
         assign nbr = chain[gi + 1];
      end
      bnpe_cell #(
         .IDX (gi),
         .UW  (UW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .used_slots (used_ff),
         .nbr_in     (nbr),
         .wr_pay     (wr_pay),
         .hole_in    (hole[gi]),
         .hole_out   (hole[gi + 1]),
         .entry_out  (chain[gi])
      );
   end

   // ---------------------------------------------------------------
   // Handshakes: take an item only when idle; the result register frees
   // up whenever the consumer is not stalling.
   // ---------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_result_key = rsp_key_ff;
   assign rsp_result_a   = rsp_a_ff;
   assign rsp_result_b   = rsp_b_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      inv_in      = inv_ff;
      used_in     = used_ff;
      cnt_in      = cnt_ff;
      hit_in      = hit_ff;
      err_in      = err_ff;
      full_in     = full_ff;
      moved_in    = moved_ff;
      res_key_in  = res_key_ff;
      res_a_in    = res_a_ff;
      res_b_in    = res_b_ff;
      res_slot_in = res_slot_ff;
      cell_cmd    = CELL_HOLD;
      tail        = '0;
      out_load    = 1'b0;
      rsp_status_in = ST_OK;
      rsp_found_in  = 1'b0;
      rsp_key_in    = '0;
      rsp_a_in      = '0;
      rsp_b_in      = '0;
      rsp_slot_in   = '0;
      rsp_last_in   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               key_in      = req_key;
               inv_in      = req_invalidate;
               cnt_in      = '0;
               hit_in      = 1'b0;
               err_in      = 1'b0;
               full_in     = 1'b0;
               moved_in    = '0;
               res_slot_in = '0;
               case (req_operation)
                  OP_INSERT: begin
                     if (used_ff >= UW'(ENTRIES)) begin
                        full_in = 1'b1;
                     end else begin
                        cell_cmd    = CELL_WRITE;
                        used_in     = UW'(used_ff + 1'b1);
                        res_slot_in = 6'(used_ff);
                     end
                     state_in = S_FINAL;
                  end
                  OP_LOOKUP, OP_SPLIT: begin
                     err_in   = !leaf_ff;
                     state_in = leaf_ff ? S_SCAN : S_FINAL;
                  end
                  OP_CHILD: begin
                     err_in   = leaf_ff;
                     state_in = leaf_ff ? S_FINAL : S_SCAN;
                  end
                  OP_COMPACT: state_in = S_COMPACT;
                  OP_MIDDLE:  state_in = S_SCAN;
                  default:    state_in = S_IDLE; // drop unknown codes
               endcase
            end
         end

         S_SCAN: begin
            // Rotate one slot only when a moved entry could be handed on
            if (out_free) begin
               cell_cmd = CELL_SHIFT;
               tail     = head;
               cnt_in   = UW'(cnt_ff + 1'b1);
               if (cnt_ff == UW'(ENTRIES - 1)) begin
                  state_in = (op_ff == OP_SPLIT) ? S_COMPACT : S_FINAL;
               end
               case (op_ff)
                  OP_LOOKUP: begin
                     if (!hit_ff && head.valid && head.pay.key == key_ff) begin
                        hit_in      = 1'b1;
                        res_key_in  = head.pay.key;
                        res_a_in    = head.pay.a;
                        res_b_in    = head.pay.b;
                        res_slot_in = 6'(cnt_ff);
                        if (inv_ff) begin
                           tail.valid = 1'b0;
                        end
                     end
                  end
                  OP_CHILD: begin
                     if (head.valid && !(head.pay.key < key_ff) &&
                         (!hit_ff || head.pay.key < res_key_ff)) begin
                        hit_in      = 1'b1;
                        res_key_in  = head.pay.key;
                        res_a_in    = head.pay.a;
                        res_b_in    = '0;
                        res_slot_in = 6'(cnt_ff);
                     end
                  end
                  OP_SPLIT: begin
                     if (head.valid && head.pay.key < key_ff &&
                         moved_ff < 7'(SPLIT_MAX)) begin
                        tail.valid = 1'b0;
                        moved_in   = moved_ff + 1'b1;
                        // hand on the previous mover, hold this one back
                        if (hit_ff) begin
                           out_load      = 1'b1;
                           rsp_status_in = ST_OK;
                           rsp_found_in  = 1'b1;
                           rsp_key_in    = res_key_ff;
                           rsp_a_in      = res_a_ff;
                           rsp_b_in      = res_b_ff;
                           rsp_slot_in   = res_slot_ff;
                           rsp_last_in   = 1'b0;
                        end
                        hit_in      = 1'b1;
                        res_key_in  = head.pay.key;
                        res_a_in    = head.pay.a;
                        res_b_in    = head.pay.b;
                        res_slot_in = 6'(cnt_ff);
                     end
                  end
                  OP_MIDDLE: begin
                     if (!hit_ff && head.valid && cnt_ff >= (used_ff >> 1)) begin
                        hit_in      = 1'b1;
                        res_key_in  = head.pay.key;
                        res_a_in    = head.pay.a;
                        res_b_in    = head.pay.b;
                        res_slot_in = 6'(cnt_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_COMPACT: begin
            // Close the lowest hole, one per cycle
            cell_cmd = CELL_COMPACT;
            if (hole_any) begin
               used_in = UW'(used_ff - 1'b1);
            end else begin
               state_in = S_FINAL;
            end
         end

         S_FINAL: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               if (err_ff) begin
                  rsp_status_in = ST_WRONG_TYPE;
               end else begin
                  case (op_ff)
                     OP_INSERT: begin
                        rsp_status_in = full_ff ? ST_FULL : ST_OK;
                        rsp_slot_in   = res_slot_ff;
                     end
                     OP_LOOKUP, OP_MIDDLE, OP_CHILD, OP_SPLIT: begin
                        if (hit_ff) begin
                           rsp_found_in = 1'b1;
                           rsp_key_in   = res_key_ff;
                           rsp_a_in     = res_a_ff;
                           rsp_b_in     = res_b_ff;
                           rsp_slot_in  = res_slot_ff;
                        end else if (op_ff == OP_CHILD) begin
                           rsp_a_in = rmc_ff;
                        end
                        if (op_ff == OP_SPLIT) begin
                           rsp_status_in = (used_ff == '0) ? ST_NO_VALID : ST_OK;
                        end else if (!hit_ff && op_ff == OP_LOOKUP) begin
                           rsp_status_in = ST_NOT_FOUND;
                        end else if (!hit_ff && op_ff == OP_MIDDLE) begin
                           rsp_status_in = ST_NO_VALID;
                        end
                     end
                     OP_COMPACT: begin
                        rsp_status_in = (used_ff == '0) ? ST_NO_VALID : ST_OK;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         leaf_ff      <= 1'b1;
         rmc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NODE_IS_LEAF:    leaf_ff <= csr_write_data[0];
               CSR_RIGHTMOST_CHILD: rmc_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item context and result payload: no reset needed
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      inv_ff      <= inv_in;
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      err_ff      <= err_in;
      full_ff     <= full_in;
      moved_ff    <= moved_in;
      res_key_ff  <= res_key_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
      res_slot_ff <= res_slot_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_a_ff      <= rsp_a_in;
         rsp_b_ff      <= rsp_b_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
`include "btree_node_page_engine_top_assert.svh"

   `BNPE_ASSERT_NEXT(a_insert_grows, accept && req_operation == OP_INSERT && used_ff < UW'(ENTRIES), used_ff == UW'($past(used_ff) + 1'b1))
   `BNPE_ASSERT_NEXT(a_scan_holds, state_ff == S_SCAN && rsp_valid_ff && rsp_stall, cnt_ff == $past(cnt_ff))
   `BNPE_ASSERT_SAME(a_compacted, state_ff == S_FINAL && !err_ff && (op_ff == OP_SPLIT || op_ff == OP_COMPACT), !hole_any)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bnpe_pkg::*;

   localparam int ROWS         = 64;
   // Scan rotates the whole row once, compaction closes one hole a cycle.
   localparam int SETTLE_TICKS = 3 * ROWS + 20;
   localparam int TICK_LIMIT   = 1000000;

   typedef struct {
      logic [2:0]         status;
      logic               found;
      logic signed [31:0] key;
      logic [15:0]        a;
      logic [15:0]        b;
      logic [5:0]         slot;
      logic               last;
   } page_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = OP_INSERT;
   logic signed [31:0] req_key = '0;
   logic [15:0]        req_value_a = '0;
   logic [15:0]        req_value_b = '0;
   logic               req_invalidate = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic               rsp_found;
   logic signed [31:0] rsp_result_key;
   logic [15:0]        rsp_result_a;
   logic [15:0]        rsp_result_b;
   logic [5:0]         rsp_slot_index;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_NODE_IS_LEAF;
   logic [15:0]        csr_write_data = '0;

   btree_node_page_engine_top #(.ENTRIES(ROWS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the page and its registers
   logic signed [31:0] row_key [ROWS];
   logic [15:0]        row_a [ROWS];
   logic [15:0]        row_b [ROWS];
   logic               row_live [ROWS];
   int                 row_count;
   logic               leaf_page;
   logic [15:0]        right_child;

   page_beat_type awaited_beats[$];
   int            mismatches = 0;
   int            ticks = 0;
   bit            quiet = 1'b0;

   function automatic void queue_beat(logic [2:0] st, logic f, logic signed [31:0] k,
                                      logic [15:0] a, logic [15:0] b, int s, logic l);
      page_beat_type r;
      r.status = st; r.found = f; r.key = k; r.a = a; r.b = b;
      r.slot = s[5:0]; r.last = l;
      awaited_beats = {awaited_beats, r};
   endfunction

   function automatic int squeeze_page();
      int n;
      n = 0;
      for (int i = 0; i < row_count; i++) begin
         if (row_live[i]) begin
            row_key[n] = row_key[i]; row_a[n] = row_a[i]; row_b[n] = row_b[i];
            row_live[n] = 1'b1;
            n++;
         end
      end
      for (int i = n; i < ROWS; i++) row_live[i] = 1'b0;
      row_count = n;
      return n;
   endfunction

   function automatic void predict_page_op(logic [2:0] op, logic signed [31:0] k,
                                           logic [15:0] a, logic [15:0] b, logic inv);
      int  best;
      int  moved;
      bit  hit;
      case (op)
         OP_INSERT: begin
            if (row_count >= ROWS) queue_beat(ST_FULL, 0, 0, 0, 0, 0, 1);
            else begin
               row_key[row_count] = k; row_a[row_count] = a; row_b[row_count] = b;
               row_live[row_count] = 1'b1;
               queue_beat(ST_OK, 0, 0, 0, 0, row_count, 1);
               row_count++;
            end
         end
         OP_LOOKUP: begin
            if (!leaf_page) queue_beat(ST_WRONG_TYPE, 0, 0, 0, 0, 0, 1);
            else begin
               hit = 0;
               for (int i = 0; i < row_count && !hit; i++) begin
                  if (row_live[i] && row_key[i] == k) begin
                     queue_beat(ST_OK, 1, row_key[i], row_a[i], row_b[i], i, 1);
                     if (inv) row_live[i] = 1'b0;
                     hit = 1;
                  end
               end
               if (!hit) queue_beat(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
            end
         end
         OP_CHILD: begin
            if (leaf_page) queue_beat(ST_WRONG_TYPE, 0, 0, 0, 0, 0, 1);
            else begin
               hit = 0; best = 0;
               for (int i = 0; i < row_count; i++) begin
                  if (row_live[i] && row_key[i] >= k && (!hit || row_key[i] < row_key[best]))
                  begin
                     hit = 1; best = i;
                  end
               end
               if (hit) queue_beat(ST_OK, 1, row_key[best], row_a[best], 0, best, 1);
               else     queue_beat(ST_OK, 0, 0, right_child, 0, 0, 1);
            end
         end
         OP_SPLIT: begin
            if (!leaf_page) queue_beat(ST_WRONG_TYPE, 0, 0, 0, 0, 0, 1);
            else begin
               moved = 0;
               for (int i = 0; i < row_count && moved < SPLIT_MAX; i++) begin
                  if (row_live[i] && row_key[i] < k) begin
                     queue_beat(ST_OK, 1, row_key[i], row_a[i], row_b[i], i, 0);
                     row_live[i] = 1'b0;
                     moved++;
                  end
               end
               if (squeeze_page() == 0) begin
                  if (moved == 0) queue_beat(ST_NO_VALID, 0, 0, 0, 0, 0, 1);
                  else awaited_beats[awaited_beats.size() - 1].status = ST_NO_VALID;
               end else if (moved == 0) queue_beat(ST_OK, 0, 0, 0, 0, 0, 1);
               if (moved != 0) awaited_beats[awaited_beats.size() - 1].last = 1'b1;
            end
         end
         OP_COMPACT: begin
            if (squeeze_page() == 0) queue_beat(ST_NO_VALID, 0, 0, 0, 0, 0, 1);
            else queue_beat(ST_OK, 0, 0, 0, 0, 0, 1);
         end
         OP_MIDDLE: begin
            hit = 0;
            for (int i = row_count / 2; i < row_count && !hit; i++) begin
               if (row_live[i]) begin
                  queue_beat(ST_OK, 1, row_key[i], row_a[i], row_b[i], i, 1);
                  hit = 1;
               end
            end
            if (!hit) queue_beat(ST_NO_VALID, 0, 0, 0, 0, 0, 1);
         end
         default: ;
      endcase
   endfunction

   // Receiver: stall at random except in quiet stretches.
   always @(posedge clock)
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 12);

   // Check each result beat in the stable half of the cycle.
   always @(negedge clock) begin
      page_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            want = awaited_beats.pop_front();
            if (rsp_status !== want.status || rsp_found !== want.found ||
                rsp_result_key !== want.key || rsp_result_a !== want.a ||
                rsp_result_b !== want.b || rsp_slot_index !== want.slot ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st%0d f%0d k%0d a%h b%h s%0d l%0d,",
                            " got st%0d f%0d k%0d a%h b%h s%0d l%0d"},
                     want.status, want.found, want.key, want.a, want.b, want.slot, want.last,
                     rsp_status, rsp_found, rsp_result_key, rsp_result_a, rsp_result_b,
                     rsp_slot_index, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      ticks++;
      if (ticks > TICK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Send one beat; entered and left at a rising edge, valid left high.
   task automatic send_item(logic [2:0] op, logic signed [31:0] k, logic [15:0] a,
                            logic [15:0] b, logic inv);
      bit taken;
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1; req_operation <= op; req_key <= k;
      req_value_a <= a; req_value_b <= b; req_invalidate <= inv;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_page_op(op, k, a, b, inv);
   endtask

   // Drop valid and wait out every pending result plus the block's own work.
   task automatic drain_page();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_NODE_IS_LEAF) leaf_page = data[0];
      else right_child = data;
   endtask

   function automatic logic signed [31:0] pick_key();
      if ($urandom_range(99) < 80) return $signed($urandom_range(31)) - 16;
      return $urandom();
   endfunction

   task automatic test_leaf_basics();
      send_item(OP_MIDDLE, 0, 0, 0, 0);
      send_item(OP_COMPACT, 0, 0, 0, 0);
      send_item(OP_LOOKUP, 5, 0, 0, 0);
      send_item(OP_SPLIT, 5, 0, 0, 0);
      send_item(OP_INSERT, 32'sh8000_0000, 16'h0000, 16'hFFFF, 0);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 16'h0000, 1);
      send_item(OP_INSERT, 0, 16'h1234, 16'h5678, 0);
      send_item(OP_INSERT, 0, 16'hAAAA, 16'h5555, 0);
      send_item(OP_LOOKUP, 0, 0, 0, 1);
      send_item(OP_LOOKUP, 0, 0, 0, 0);
      send_item(OP_LOOKUP, 32'sh7FFF_FFFF, 0, 0, 0);
      send_item(OP_MIDDLE, 0, 0, 0, 0);
      send_item(OP_CHILD, 0, 0, 0, 0);
      send_item(3'd6, 1, 2, 3, 1);
      send_item(OP_SPLIT, 1, 0, 0, 0);
      send_item(OP_LOOKUP, 32'sh7FFF_FFFF, 0, 0, 1);
      send_item(OP_SPLIT, 32'sh7FFF_FFFF, 0, 0, 0);
      drain_page();
   endtask

   task automatic test_internal_basics();
      write_reg(CSR_NODE_IS_LEAF, 16'd0);
      write_reg(CSR_RIGHTMOST_CHILD, 16'hFFFF);
      send_item(OP_CHILD, 0, 0, 0, 0);
      send_item(OP_INSERT, 10, 16'h0010, 16'h0001, 0);
      send_item(OP_INSERT, 20, 16'h0020, 16'h0002, 0);
      send_item(OP_INSERT, 10, 16'h0011, 16'h0003, 0);
      send_item(OP_CHILD, 5, 0, 0, 0);
      send_item(OP_CHILD, 15, 0, 0, 0);
      send_item(OP_CHILD, 21, 0, 0, 0);
      send_item(OP_LOOKUP, 10, 0, 0, 1);
      send_item(OP_SPLIT, 30, 0, 0, 0);
      send_item(OP_MIDDLE, 0, 0, 0, 0);
      send_item(3'd7, 0, 0, 0, 0);
      send_item(OP_COMPACT, 0, 0, 0, 0);
      drain_page();
   endtask

   task automatic test_full_page();
      for (int i = row_count; i <= ROWS; i++)
         send_item(OP_INSERT, pick_key(), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 0);
      drain_page();
      write_reg(CSR_NODE_IS_LEAF, 16'd1);
      send_item(OP_SPLIT, 32'sh7FFF_FFFF, 0, 0, 0);
      drain_page();
   endtask

   task automatic test_random_mix(int count, bit with_pause);
      int          w;
      logic [2:0]  op;
      for (int n = 0; n < count; n++) begin
         quiet = (n >= count / 3 && n < count / 2);
         if (with_pause && n == count / 2) begin
            req_valid <= 1'b0;
            while (awaited_beats.size() != 0) @(posedge clock);
         end
         w = $urandom_range(99);
         if (w < 35)      op = OP_INSERT;
         else if (w < 55) op = OP_LOOKUP;
         else if (w < 68) op = OP_CHILD;
         else if (w < 77) op = OP_SPLIT;
         else if (w < 84) op = OP_COMPACT;
         else if (w < 96) op = OP_MIDDLE;
         else             op = 3'($urandom_range(6, 7));
         send_item(op, pick_key(), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   1'($urandom_range(1)));
      end
      quiet = 1'b0;
      drain_page();
   endtask

   initial begin
      for (int i = 0; i < ROWS; i++) begin
         row_key[i] = '0; row_a[i] = '0; row_b[i] = '0; row_live[i] = 1'b0;
      end
      row_count = 0; leaf_page = 1'b1; right_child = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_leaf_basics();
      test_internal_basics();
      test_full_page();
      // Sweep the registers through their extremes and random settings.
      write_reg(CSR_RIGHTMOST_CHILD, 16'h0000);
      test_random_mix(50, 0);
      write_reg(CSR_NODE_IS_LEAF, 16'd0);
      write_reg(CSR_RIGHTMOST_CHILD, 16'hFFFF);
      test_random_mix(40, 1);
      write_reg(CSR_NODE_IS_LEAF, 16'd1);
      write_reg(CSR_RIGHTMOST_CHILD, 16'($urandom_range(65535)));
      test_random_mix(70, 0);
      write_reg(CSR_NODE_IS_LEAF, 16'd0);
      write_reg(CSR_RIGHTMOST_CHILD, 16'($urandom_range(65535)));
      test_random_mix(40, 0);
      write_reg(CSR_NODE_IS_LEAF, 16'd1);
      write_reg(CSR_RIGHTMOST_CHILD, 16'h5A5A);
      test_random_mix(60, 1);
      if (mismatches == 0 && awaited_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
